>>> sv/gas_pkg.sv
package gas_pkg;

  // Event codes carried in the kind field of a request.
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_PRESS  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // Alarm levels.
  localparam logic [2:0] LVL_NONE       = 3'd0;
  localparam logic [2:0] LVL_WARN_LOW   = 3'd1;
  localparam logic [2:0] LVL_WARN_HIGH  = 3'd2;
  localparam logic [2:0] LVL_NO_DATA    = 3'd3;
  localparam logic [2:0] LVL_ALARM_LOW  = 3'd4;
  localparam logic [2:0] LVL_ALARM_HIGH = 3'd5;

  // Sound request codes.
  localparam logic [1:0] SND_NONE  = 2'd0;
  localparam logic [1:0] SND_WARN  = 2'd1;
  localparam logic [1:0] SND_ALARM = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_ALARMS_ENABLED  = 3'd0;
  localparam logic [2:0] REG_ALARM_LOW       = 3'd1;
  localparam logic [2:0] REG_WARN_LOW        = 3'd2;
  localparam logic [2:0] REG_ALARM_HIGH      = 3'd3;
  localparam logic [2:0] REG_WARN_HIGH       = 3'd4;
  localparam logic [2:0] REG_STALE_MINUTES   = 3'd5;
  localparam logic [2:0] REG_REPEAT_MINUTES  = 3'd6;
  localparam logic [2:0] REG_SNOOZE_UNIT     = 3'd7;

  localparam int unsigned ADDR_W = 5;

  // Time constants and limits.
  localparam logic [31:0] MS_PER_SEC      = 32'd1000;
  localparam logic [31:0] PRESS_WINDOW_MS = 32'd2000;
  localparam logic [15:0] MS_PER_MIN      = 16'd60000;
  localparam logic [31:0] ROUND_UP_MS     = 32'd59999;
  localparam logic [9:0]  LOW_VALID_MIN   = 10'd10;
  localparam logic [2:0]  MAX_STEP        = 3'd4;
  localparam logic [9:0]  LEFT_MAX        = 10'd1023;

  // Rounded-up time at or above this gives more than 1023 minutes.
  localparam logic [31:0] LEFT_SAT_MS = 32'd61440000;
  // ceil(2^32 / 1875); exact quotient for dividends below 2^21.
  localparam logic [21:0] RECIP_1875 = 22'd2290650;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_ms;
    logic        have_reading;
    logic [9:0]  glucose_mgdl;
    logic [9:0]  reading_age_min;
  } evt_t;

  typedef struct packed {
    logic [2:0] alarm_level;
    logic       evaluated;
    logic       changed;
    logic [1:0] sound_request;
    logic [2:0] snooze_step;
    logic [9:0] snooze_left_min;
  } res_t;

  typedef struct packed {
    logic       alarms_enabled;
    logic [9:0] alarm_low_level;
    logic [9:0] warn_low_level;
    logic [9:0] alarm_high_level;
    logic [9:0] warn_high_level;
    logic [9:0] stale_minutes;
    logic [7:0] repeat_minutes;
    logic [7:0] snooze_unit_minutes;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic scale;
    logic commit;
    logic divide;
    logic finish;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCALE,
    ST_COMMIT,
    ST_DIV,
    ST_FINISH
  } state_t;

endpackage

>>> sv/gas_ctrl.sv
module gas_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          evt_valid,
  input  logic          out_free,
  output logic          evt_stall,
  output gas_pkg::cmd_t cmd
);

  gas_pkg::state_t state;
  gas_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gas_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      gas_pkg::ST_IDLE: begin
        if (evt_valid) begin
          state_next = gas_pkg::ST_EVAL;
        end
      end
      gas_pkg::ST_EVAL:   state_next = gas_pkg::ST_SCALE;
      gas_pkg::ST_SCALE:  state_next = gas_pkg::ST_COMMIT;
      gas_pkg::ST_COMMIT: state_next = gas_pkg::ST_DIV;
      gas_pkg::ST_DIV:    state_next = gas_pkg::ST_FINISH;
      gas_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = gas_pkg::ST_IDLE;
        end
      end
      default: state_next = gas_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    evt_stall = 1'b1;
    case (state)
      gas_pkg::ST_IDLE: begin
        evt_stall = 1'b0;
        cmd.load  = evt_valid;
      end
      gas_pkg::ST_EVAL:   cmd.eval   = 1'b1;
      gas_pkg::ST_SCALE:  cmd.scale  = 1'b1;
      gas_pkg::ST_COMMIT: cmd.commit = 1'b1;
      gas_pkg::ST_DIV:    cmd.divide = 1'b1;
      gas_pkg::ST_FINISH: cmd.finish = out_free;
      default: begin
        evt_stall = 1'b1;
      end
    endcase
  end

endmodule

>>> sv/gas_dp.sv
module gas_dp (
  input  logic          clk,
  input  logic          rst,
  input  gas_pkg::cfg_t cfg,
  input  gas_pkg::cmd_t cmd,
  input  gas_pkg::evt_t evt,
  output logic          out_free,
  output logic          res_valid,
  input  logic          res_stall,
  output gas_pkg::res_t res
);

  // Captured request.
  gas_pkg::evt_t item;

  // Supervisor state.
  logic [31:0] last_eval_time;
  logic [2:0]  level_now;
  logic        has_sounded;
  logic [31:0] last_sound_time;
  logic [31:0] last_press_time;
  logic [2:0]  snooze_multiplier;
  logic [31:0] snooze_expiry;

  // Working registers.
  logic        rate_ok;
  logic [2:0]  lvl_new;
  logic        snz_act_old;
  logic [31:0] since_sound;
  logic [23:0] rep_ms;
  logic [2:0]  mult_new;
  logic [10:0] unit_prod;
  logic        due;
  logic [25:0] snz_ms;
  logic        r_evaluated;
  logic        r_changed;
  logic [1:0]  r_sound;
  logic        left_active;
  logic        left_sat;
  logic [42:0] div_prod;

  // Combinational helpers.
  logic [2:0]  lvl_comb;
  logic        snz_act_comb;
  logic [31:0] eval_gap;
  logic [31:0] press_gap;
  logic [2:0]  mult_comb;
  logic [31:0] exp_gap;
  logic        left_active_comb;
  logic [31:0] left_round;
  logic [20:0] left_scaled;
  logic [9:0]  left_min;

  function automatic logic active_at(input logic [31:0] expiry, input logic [31:0] now);
    logic [31:0] d;
    d = expiry - now;
    return (expiry != 32'd0) && (d != 32'd0) && !d[31];
  endfunction

  always_comb begin
    if (!cfg.alarms_enabled || !item.have_reading) begin
      lvl_comb = gas_pkg::LVL_NONE;
    end else if (item.glucose_mgdl >= gas_pkg::LOW_VALID_MIN &&
                 item.glucose_mgdl <= cfg.alarm_low_level) begin
      lvl_comb = gas_pkg::LVL_ALARM_LOW;
    end else if (item.glucose_mgdl >= gas_pkg::LOW_VALID_MIN &&
                 item.glucose_mgdl <= cfg.warn_low_level) begin
      lvl_comb = gas_pkg::LVL_WARN_LOW;
    end else if (item.glucose_mgdl >= cfg.alarm_high_level) begin
      lvl_comb = gas_pkg::LVL_ALARM_HIGH;
    end else if (item.glucose_mgdl >= cfg.warn_high_level) begin
      lvl_comb = gas_pkg::LVL_WARN_HIGH;
    end else if (item.reading_age_min >= cfg.stale_minutes) begin
      lvl_comb = gas_pkg::LVL_NO_DATA;
    end else begin
      lvl_comb = gas_pkg::LVL_NONE;
    end
  end

  always_comb begin
    eval_gap     = item.now_ms - last_eval_time;
    press_gap    = item.now_ms - last_press_time;
    snz_act_comb = active_at(snooze_expiry, item.now_ms);
    if (press_gap < gas_pkg::PRESS_WINDOW_MS) begin
      mult_comb = (snooze_multiplier >= gas_pkg::MAX_STEP) ? 3'd0 : snooze_multiplier + 3'd1;
    end else begin
      mult_comb = 3'd1;
    end
  end

  // Remaining snooze time: ceil(d / 60000) as floor((d + 59999) / 32 / 1875).
  always_comb begin
    exp_gap          = snooze_expiry - item.now_ms;
    left_active_comb = active_at(snooze_expiry, item.now_ms);
    left_round       = exp_gap + gas_pkg::ROUND_UP_MS;
    left_scaled      = left_round[25:5];
    if (!left_active) begin
      left_min = 10'd0;
    end else if (left_sat) begin
      left_min = gas_pkg::LEFT_MAX;
    end else begin
      left_min = div_prod[41:32];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= evt;
    end
    if (cmd.eval) begin
      rate_ok     <= eval_gap >= gas_pkg::MS_PER_SEC;
      lvl_new     <= lvl_comb;
      snz_act_old <= snz_act_comb;
      since_sound <= item.now_ms - last_sound_time;
      rep_ms      <= 24'(cfg.repeat_minutes) * 24'(gas_pkg::MS_PER_MIN);
      mult_new    <= mult_comb;
      unit_prod   <= 11'(mult_comb) * 11'(cfg.snooze_unit_minutes);
    end
    if (cmd.scale) begin
      due    <= !has_sounded || (since_sound > {8'd0, rep_ms});
      snz_ms <= 26'(unit_prod) * 26'(gas_pkg::MS_PER_MIN);
    end
    if (cmd.divide) begin
      left_active <= left_active_comb;
      left_sat    <= left_round >= gas_pkg::LEFT_SAT_MS;
      div_prod    <= 43'(left_scaled) * 43'(gas_pkg::RECIP_1875);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_eval_time    <= 32'd0;
      level_now         <= gas_pkg::LVL_NONE;
      has_sounded       <= 1'b0;
      last_sound_time   <= 32'd0;
      last_press_time   <= 32'd0;
      snooze_multiplier <= 3'd0;
      snooze_expiry     <= 32'd0;
      r_evaluated       <= 1'b0;
      r_changed         <= 1'b0;
      r_sound           <= gas_pkg::SND_NONE;
    end else if (cmd.commit) begin
      r_evaluated <= 1'b0;
      r_changed   <= 1'b0;
      r_sound     <= gas_pkg::SND_NONE;
      case (item.kind)
        gas_pkg::KIND_TICK: begin
          if (rate_ok) begin
            last_eval_time <= item.now_ms;
            r_evaluated    <= 1'b1;
            level_now      <= lvl_new;
            r_changed      <= lvl_new != level_now;
            if (lvl_new != gas_pkg::LVL_NONE && !snz_act_old && due) begin
              last_sound_time <= item.now_ms;
              has_sounded     <= 1'b1;
              r_sound <= (lvl_new == gas_pkg::LVL_ALARM_LOW ||
                          lvl_new == gas_pkg::LVL_ALARM_HIGH) ?
                         gas_pkg::SND_ALARM : gas_pkg::SND_WARN;
            end
          end
        end
        gas_pkg::KIND_PRESS: begin
          snooze_multiplier <= mult_new;
          last_press_time   <= item.now_ms;
          snooze_expiry     <= (mult_new == 3'd0) ? 32'd0 : item.now_ms + {6'd0, snz_ms};
          r_changed         <= 1'b1;
        end
        gas_pkg::KIND_CLEAR: begin
          snooze_multiplier <= 3'd0;
          snooze_expiry     <= 32'd0;
          r_changed         <= 1'b1;
        end
        default: begin
          r_changed <= 1'b0;
        end
      endcase
    end
  end

  assign out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.finish) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res.alarm_level     <= level_now;
      res.evaluated       <= r_evaluated;
      res.changed         <= r_changed;
      res.sound_request   <= r_sound;
      res.snooze_step     <= snooze_multiplier;
      res.snooze_left_min <= left_min;
    end
  end

endmodule

>>> sv/glucose_alarm_supervisor.sv
// Glucose alarm supervisor. Each request (tick, snooze press or clear) yields exactly one
// result. The controller steps one request through classification, two multiply stages
// for the repeat and snooze intervals, the state update, and a reciprocal multiply that
// gives the remaining snooze minutes, then loads the result into the output register.
// The next request is accepted the cycle after the result is loaded, so requests never
// overlap, and a result left waiting holds back only the request after it. Configuration
// registers sit at byte addresses 4*i on the APB port and are to be written by the user
// only while no request is in flight; the block itself does not enforce this.
module glucose_alarm_supervisor (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gas_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       evt_valid,
  output logic                       evt_stall,
  input  gas_pkg::evt_t              evt,
  output logic                       res_valid,
  input  logic                       res_stall,
  output gas_pkg::res_t              res
);

  gas_pkg::cfg_t cfg;
  gas_pkg::cmd_t cmd;
  logic          out_free;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alarms_enabled      <= 1'b1;
      cfg.alarm_low_level     <= 10'd55;
      cfg.warn_low_level      <= 10'd80;
      cfg.alarm_high_level    <= 10'd260;
      cfg.warn_high_level     <= 10'd180;
      cfg.stale_minutes       <= 10'd15;
      cfg.repeat_minutes      <= 8'd5;
      cfg.snooze_unit_minutes <= 8'd30;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        gas_pkg::REG_ALARMS_ENABLED: cfg.alarms_enabled      <= pwdata[0];
        gas_pkg::REG_ALARM_LOW:      cfg.alarm_low_level     <= pwdata[9:0];
        gas_pkg::REG_WARN_LOW:       cfg.warn_low_level      <= pwdata[9:0];
        gas_pkg::REG_ALARM_HIGH:     cfg.alarm_high_level    <= pwdata[9:0];
        gas_pkg::REG_WARN_HIGH:      cfg.warn_high_level     <= pwdata[9:0];
        gas_pkg::REG_STALE_MINUTES:  cfg.stale_minutes       <= pwdata[9:0];
        gas_pkg::REG_REPEAT_MINUTES: cfg.repeat_minutes      <= pwdata[7:0];
        gas_pkg::REG_SNOOZE_UNIT:    cfg.snooze_unit_minutes <= pwdata[7:0];
        default:                     cfg.alarms_enabled      <= cfg.alarms_enabled;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gas_pkg::REG_ALARMS_ENABLED: prdata = {31'd0, cfg.alarms_enabled};
      gas_pkg::REG_ALARM_LOW:      prdata = {22'd0, cfg.alarm_low_level};
      gas_pkg::REG_WARN_LOW:       prdata = {22'd0, cfg.warn_low_level};
      gas_pkg::REG_ALARM_HIGH:     prdata = {22'd0, cfg.alarm_high_level};
      gas_pkg::REG_WARN_HIGH:      prdata = {22'd0, cfg.warn_high_level};
      gas_pkg::REG_STALE_MINUTES:  prdata = {22'd0, cfg.stale_minutes};
      gas_pkg::REG_REPEAT_MINUTES: prdata = {24'd0, cfg.repeat_minutes};
      gas_pkg::REG_SNOOZE_UNIT:    prdata = {24'd0, cfg.snooze_unit_minutes};
      default:                     prdata = 32'd0;
    endcase
  end

  gas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .out_free  (out_free),
    .evt_stall (evt_stall),
    .cmd       (cmd)
  );

  gas_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .evt       (evt),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

>>> sim/glucose_alarm_supervisor_tb.sv
module glucose_alarm_supervisor_tb;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [gas_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;

  logic          evt_valid = 1'b0;
  logic          evt_stall;
  gas_pkg::evt_t evt = '0;
  logic          res_valid;
  logic          res_stall = 1'b0;
  gas_pkg::res_t res;

  glucose_alarm_supervisor i_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #6 clk = ~clk;

  // Register image, starting from the reset values.
  gas_pkg::cfg_t cfg_model = '{alarms_enabled: 1'b1, alarm_low_level: 10'd55,
                               warn_low_level: 10'd80, alarm_high_level: 10'd260,
                               warn_high_level: 10'd180, stale_minutes: 10'd15,
                               repeat_minutes: 8'd5, snooze_unit_minutes: 8'd30};

  logic [31:0] last_tick_ms = '0;
  logic [2:0]  level_q = gas_pkg::LVL_NONE;
  logic        sounded = 1'b0;
  logic [31:0] last_sound_ms = '0;
  logic [31:0] last_press_ms = '0;
  logic [2:0]  snooze_mult = '0;
  logic [31:0] snooze_end_ms = '0;

  gas_pkg::evt_t evt_queue[$];
  gas_pkg::res_t res_due[$];
  gas_pkg::res_t want;

  int send_idle_pct = 22;
  int recv_idle_pct = 53;
  int errors = 0;
  int queued_count = 0;
  int checked_count = 0;
  int ticks_evaluated = 0;
  int sounds_seen = 0;
  int presses_seen = 0;
  int clears_seen = 0;
  int settings_used = 1;
  logic [31:0] t_ms = '0;

  function automatic logic [2:0] glucose_class(input gas_pkg::evt_t e);
    if (!cfg_model.alarms_enabled || !e.have_reading) return gas_pkg::LVL_NONE;
    if (e.glucose_mgdl >= gas_pkg::LOW_VALID_MIN &&
        e.glucose_mgdl <= cfg_model.alarm_low_level)
      return gas_pkg::LVL_ALARM_LOW;
    if (e.glucose_mgdl >= gas_pkg::LOW_VALID_MIN &&
        e.glucose_mgdl <= cfg_model.warn_low_level)
      return gas_pkg::LVL_WARN_LOW;
    if (e.glucose_mgdl >= cfg_model.alarm_high_level) return gas_pkg::LVL_ALARM_HIGH;
    if (e.glucose_mgdl >= cfg_model.warn_high_level) return gas_pkg::LVL_WARN_HIGH;
    if (e.reading_age_min >= cfg_model.stale_minutes) return gas_pkg::LVL_NO_DATA;
    return gas_pkg::LVL_NONE;
  endfunction

  // The snooze runs while its end lies strictly ahead, compared with wrapping time.
  function automatic logic snooze_running(input logic [31:0] now);
    logic [31:0] d;
    d = snooze_end_ms - now;
    return snooze_end_ms != 0 && d != 0 && !d[31];
  endfunction

  function automatic logic [9:0] minutes_left(input logic [31:0] now);
    logic [31:0] m;
    if (!snooze_running(now)) return '0;
    m = (snooze_end_ms - now + gas_pkg::ROUND_UP_MS) / 32'd60000;
    return (m > 32'd1023) ? gas_pkg::LEFT_MAX : m[9:0];
  endfunction

  function automatic gas_pkg::res_t alarm_step(input gas_pkg::evt_t e);
    gas_pkg::res_t r;
    logic [2:0] lvl;
    logic [31:0] gap;
    logic [31:0] rep_ms;
    r = '0;
    case (e.kind)
      gas_pkg::KIND_TICK: begin
        gap = e.now_ms - last_tick_ms;
        if (gap >= gas_pkg::MS_PER_SEC) begin
          last_tick_ms = e.now_ms;
          r.evaluated = 1'b1;
          ticks_evaluated++;
          lvl = glucose_class(e);
          if (lvl != level_q) begin
            level_q = lvl;
            r.changed = 1'b1;
          end
          rep_ms = 32'(cfg_model.repeat_minutes) * 32'd60000;
          gap = e.now_ms - last_sound_ms;
          if (lvl != gas_pkg::LVL_NONE && !snooze_running(e.now_ms) &&
              (!sounded || gap > rep_ms)) begin
            last_sound_ms = e.now_ms;
            sounded = 1'b1;
            sounds_seen++;
            r.sound_request = (lvl == gas_pkg::LVL_ALARM_LOW ||
                               lvl == gas_pkg::LVL_ALARM_HIGH) ?
                              gas_pkg::SND_ALARM : gas_pkg::SND_WARN;
          end
        end
      end
      gas_pkg::KIND_PRESS: begin
        gap = e.now_ms - last_press_ms;
        if (gap < gas_pkg::PRESS_WINDOW_MS)
          snooze_mult = (snooze_mult >= gas_pkg::MAX_STEP) ? 3'd0 : snooze_mult + 3'd1;
        else
          snooze_mult = 3'd1;
        last_press_ms = e.now_ms;
        snooze_end_ms = (snooze_mult == 0) ? 32'd0 :
                        e.now_ms + 32'(snooze_mult) * 32'(cfg_model.snooze_unit_minutes) *
                        32'd60000;
        r.changed = 1'b1;
        presses_seen++;
      end
      gas_pkg::KIND_CLEAR: begin
        snooze_end_ms = '0;
        snooze_mult = '0;
        r.changed = 1'b1;
        clears_seen++;
      end
      default: begin
      end
    endcase
    r.alarm_level = level_q;
    r.snooze_step = snooze_mult;
    r.snooze_left_min = minutes_left(e.now_ms);
    return r;
  endfunction

  // Request driver: a new request is offered only when the last one has gone.
  always @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (!evt_valid || !evt_stall) begin
      if (evt_valid) res_due.push_back(alarm_step(evt));
      if (evt_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        evt <= evt_queue.pop_front();
        evt_valid <= 1'b1;
      end else begin
        evt_valid <= 1'b0;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (res_due.size() == 0) begin
          $error("result arrived with no request outstanding");
          errors++;
        end else begin
          want = res_due.pop_front();
          checked_count++;
          if (res.alarm_level !== want.alarm_level) begin
            $error("alarm_level: expected %0d, got %0d", want.alarm_level, res.alarm_level);
            errors++;
          end
          if (res.evaluated !== want.evaluated) begin
            $error("evaluated: expected %0d, got %0d", want.evaluated, res.evaluated);
            errors++;
          end
          if (res.changed !== want.changed) begin
            $error("changed: expected %0d, got %0d", want.changed, res.changed);
            errors++;
          end
          if (res.sound_request !== want.sound_request) begin
            $error("sound_request: expected %0d, got %0d", want.sound_request,
                   res.sound_request);
            errors++;
          end
          if (res.snooze_step !== want.snooze_step) begin
            $error("snooze_step: expected %0d, got %0d", want.snooze_step, res.snooze_step);
            errors++;
          end
          if (res.snooze_left_min !== want.snooze_left_min) begin
            $error("snooze_left_min: expected %0d, got %0d", want.snooze_left_min,
                   res.snooze_left_min);
            errors++;
          end
        end
      end
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic queue_evt(input logic [1:0] k, input logic [31:0] now, input logic have,
                           input logic [9:0] g, input logic [9:0] age);
    gas_pkg::evt_t e;
    e.kind = k;
    e.now_ms = now;
    e.have_reading = have;
    e.glucose_mgdl = g;
    e.reading_age_min = age;
    evt_queue.push_back(e);
    queued_count++;
  endtask

  // Blocks until every queued request has had its result checked.
  task automatic wait_idle();
    while (checked_count != queued_count) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val | ($urandom() & 32'hFFFF_FC00);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      gas_pkg::REG_ALARMS_ENABLED: cfg_model.alarms_enabled = val[0];
      gas_pkg::REG_ALARM_LOW:      cfg_model.alarm_low_level = val[9:0];
      gas_pkg::REG_WARN_LOW:       cfg_model.warn_low_level = val[9:0];
      gas_pkg::REG_ALARM_HIGH:     cfg_model.alarm_high_level = val[9:0];
      gas_pkg::REG_WARN_HIGH:      cfg_model.warn_high_level = val[9:0];
      gas_pkg::REG_STALE_MINUTES:  cfg_model.stale_minutes = val[9:0];
      gas_pkg::REG_REPEAT_MINUTES: cfg_model.repeat_minutes = val[7:0];
      gas_pkg::REG_SNOOZE_UNIT:    cfg_model.snooze_unit_minutes = val[7:0];
      default: begin
      end
    endcase
  endtask

  task automatic apply_setting(input int which);
    logic [31:0] v[8];
    v[0] = 32'd1;
    v[1] = $urandom_range(70, 40);
    v[2] = $urandom_range(100, 70);
    v[3] = $urandom_range(350, 220);
    v[4] = $urandom_range(220, 150);
    v[5] = $urandom_range(30, 5);
    v[6] = $urandom_range(10);
    v[7] = $urandom_range(60);
    case (which)
      1: begin
        for (int i = 1; i < 8; i++) v[i] = '0;
      end
      2: begin
        for (int i = 1; i < 6; i++) v[i] = 32'd1023;
        v[6] = 32'd255;
        v[7] = 32'd255;
      end
      3: begin
        v[6] = '0;
        v[7] = 32'd255;
      end
      4: begin
        v[0] = '0;
        for (int i = 1; i < 6; i++) v[i] = $urandom_range(1023);
        v[6] = $urandom_range(255);
        v[7] = $urandom_range(255);
      end
      default: begin
      end
    endcase
    reg_write(gas_pkg::REG_ALARMS_ENABLED, v[0]);
    reg_write(gas_pkg::REG_ALARM_LOW, v[1]);
    reg_write(gas_pkg::REG_WARN_LOW, v[2]);
    reg_write(gas_pkg::REG_ALARM_HIGH, v[3]);
    reg_write(gas_pkg::REG_WARN_HIGH, v[4]);
    reg_write(gas_pkg::REG_STALE_MINUTES, v[5]);
    reg_write(gas_pkg::REG_REPEAT_MINUTES, v[6]);
    reg_write(gas_pkg::REG_SNOOZE_UNIT, v[7]);
    settings_used++;
  endtask

  // Mostly steps past the one-second limit, some within it, some long enough for a
  // snooze to run out, and now and then a jump backwards or anywhere.
  task automatic advance_time();
    int r;
    r = $urandom_range(99);
    if (r < 15) t_ms += $urandom_range(999);
    else if (r < 60) t_ms += $urandom_range(1500, 1000);
    else if (r < 85) t_ms += $urandom_range(120000, 1001);
    else if (r < 95) t_ms += $urandom_range(4000000, 120001);
    else if (r < 98) t_ms -= $urandom_range(200000000, 1);
    else t_ms = $urandom();
  endtask

  function automatic logic [9:0] pick_glucose();
    case ($urandom_range(5))
      0: return 10'($urandom_range(1023));
      1: return 10'($urandom_range(15));
      2: return cfg_model.alarm_low_level + 10'($urandom_range(4)) - 10'd2;
      3: return cfg_model.warn_low_level + 10'($urandom_range(4)) - 10'd2;
      4: return cfg_model.alarm_high_level + 10'($urandom_range(4)) - 10'd2;
      default: return cfg_model.warn_high_level + 10'($urandom_range(4)) - 10'd2;
    endcase
  endfunction

  function automatic logic [9:0] pick_age();
    case ($urandom_range(3))
      0, 1: return cfg_model.stale_minutes + 10'($urandom_range(4)) - 10'd2;
      2: return 10'($urandom_range(20));
      default: return 10'($urandom_range(1023));
    endcase
  endfunction

  task automatic random_traffic(input int n);
    int sent;
    int pick;
    int burst;
    int r;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        advance_time();
        queue_evt(gas_pkg::KIND_TICK, t_ms, $urandom_range(99) < 92, pick_glucose(),
                  pick_age());
        sent++;
      end else if (pick < 90) begin
        // A burst of presses, mostly inside the step-up window.
        burst = $urandom_range(6, 1);
        advance_time();
        for (int j = 0; j < burst; j++) begin
          if (j > 0) begin
            r = $urandom_range(9);
            if (r < 8) t_ms += $urandom_range(1999);
            else if (r == 8) t_ms += 32'd2000;
            else t_ms += $urandom_range(5000, 2001);
          end
          queue_evt(gas_pkg::KIND_PRESS, t_ms, 1'($urandom_range(1)),
                    10'($urandom_range(1023)), 10'($urandom_range(1023)));
          sent++;
        end
      end else begin
        advance_time();
        queue_evt((pick < 97) ? gas_pkg::KIND_CLEAR : KIND_UNUSED, t_ms,
                  1'($urandom_range(1)), 10'($urandom_range(1023)),
                  10'($urandom_range(1023)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed requests under the reset settings.
    queue_evt(gas_pkg::KIND_TICK, 32'd500, 1'b1, 10'd100, 10'd0);
    queue_evt(gas_pkg::KIND_TICK, 32'd1000, 1'b1, 10'd100, 10'd0);
    queue_evt(gas_pkg::KIND_TICK, 32'd2000, 1'b1, 10'd55, 10'd0);
    queue_evt(gas_pkg::KIND_TICK, 32'd2500, 1'b1, 10'd55, 10'd0);
    queue_evt(gas_pkg::KIND_TICK, 32'd3000, 1'b1, 10'd9, 10'd0);
    queue_evt(gas_pkg::KIND_TICK, 32'd4000, 1'b1, 10'd80, 10'd0);
    queue_evt(gas_pkg::KIND_TICK, 32'd5000, 1'b1, 10'd260, 10'd0);
    queue_evt(gas_pkg::KIND_TICK, 32'd6000, 1'b1, 10'd180, 10'd0);
    queue_evt(gas_pkg::KIND_TICK, 32'd7000, 1'b1, 10'd120, 10'd15);
    queue_evt(gas_pkg::KIND_TICK, 32'd8000, 1'b0, 10'd1023, 10'd1023);
    queue_evt(gas_pkg::KIND_TICK, 32'd9000, 1'b1, 10'd0, 10'd1023);
    queue_evt(gas_pkg::KIND_TICK, 32'd400000, 1'b1, 10'd1023, 10'd0);
    queue_evt(gas_pkg::KIND_PRESS, 32'd401000, 1'b0, 10'd0, 10'd0);
    queue_evt(gas_pkg::KIND_PRESS, 32'd402000, 1'b0, 10'd0, 10'd0);
    queue_evt(gas_pkg::KIND_PRESS, 32'd403999, 1'b0, 10'd0, 10'd0);
    queue_evt(gas_pkg::KIND_PRESS, 32'd405000, 1'b0, 10'd0, 10'd0);
    queue_evt(gas_pkg::KIND_PRESS, 32'd406000, 1'b0, 10'd0, 10'd0);
    queue_evt(gas_pkg::KIND_PRESS, 32'd408000, 1'b0, 10'd0, 10'd0);
    queue_evt(gas_pkg::KIND_TICK, 32'd409000, 1'b1, 10'd40, 10'd0);
    queue_evt(gas_pkg::KIND_CLEAR, 32'd410000, 1'b0, 10'd0, 10'd0);
    queue_evt(KIND_UNUSED, 32'hFFFF_FFFF, 1'b1, 10'd1023, 10'd1023);
    queue_evt(gas_pkg::KIND_TICK, 32'd800000, 1'b1, 10'd70, 10'd0);
    queue_evt(gas_pkg::KIND_PRESS, 32'd801000, 1'b0, 10'd0, 10'd0);
    // The snooze has run out here, but its step stays until the next press or clear.
    queue_evt(gas_pkg::KIND_TICK, 32'd3000000, 1'b1, 10'd70, 10'd0);
    queue_evt(gas_pkg::KIND_PRESS, 32'd3001000, 1'b0, 10'd0, 10'd0);
    // Time jumps back far enough that the minutes left saturate.
    queue_evt(gas_pkg::KIND_TICK, 32'hF000_0000, 1'b1, 10'd70, 10'd0);
    wait_idle();

    t_ms = 32'hF000_0000;
    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        send_idle_pct = 53;
        recv_idle_pct = 22;
      end else if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_setting((seg == 5) ? 0 : seg + 1);
      if (seg == 3) t_ms = 32'hFFF0_0000;
      if (seg == 2) begin
        // The sender holds back halfway until every result is in.
        random_traffic(100);
        wait_idle();
        random_traffic(105);
      end else begin
        random_traffic(205);
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d requests under %0d register settings: %0d evaluated ticks,",
             queued_count, settings_used, ticks_evaluated);
    $display("  %0d sound requests, %0d snooze presses, %0d clears.",
             sounds_seen, presses_seen, clears_seen);
    if (errors == 0 && res_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
